>>> hdl/fcd_pkg.sv
// Shared constants and types for the frame change detector.
package fcd_pkg;

  localparam int unsigned MAX_PIXELS = 2097152;
  localparam int unsigned PIX_AW     = $clog2(MAX_PIXELS);
  localparam int unsigned IDX_W      = 21;
  localparam int unsigned CNT_W      = 22;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned PIX_W      = 3 * CH_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DAT_W  = 8;
  localparam int unsigned MODE_W     = 2;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam logic [MODE_W-1:0] MODE_COUNT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REPORT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOL_CH0 = 2'd0,
    REG_TOL_CH1 = 2'd1,
    REG_TOL_CH2 = 2'd2,
    REG_MODE    = 2'd3
  } cfg_idx_t;

endpackage

>>> hdl/fcd_if.sv
// Pixel input and result channel interfaces.
interface fcd_pix_if;
  logic                     valid;
  logic                     ready;
  logic [fcd_pkg::CH_W-1:0] pix_ch0;
  logic [fcd_pkg::CH_W-1:0] pix_ch1;
  logic [fcd_pkg::CH_W-1:0] pix_ch2;
  logic                     last_of_frame;

  modport source (output valid, pix_ch0, pix_ch1, pix_ch2, last_of_frame, input ready);
  modport sink   (input valid, pix_ch0, pix_ch1, pix_ch2, last_of_frame, output ready);
endinterface

interface fcd_res_if;
  logic                      valid;
  logic                      ready;
  logic [fcd_pkg::IDX_W-1:0] pixel_index;
  logic [fcd_pkg::CH_W-1:0]  out_ch0;
  logic [fcd_pkg::CH_W-1:0]  out_ch1;
  logic [fcd_pkg::CH_W-1:0]  out_ch2;
  logic                      changed;
  logic                      frame_done;
  logic [fcd_pkg::CNT_W-1:0] change_count;

  modport source (output valid, pixel_index, out_ch0, out_ch1, out_ch2, changed,
                  frame_done, change_count, input ready);
  modport sink   (input valid, pixel_index, out_ch0, out_ch1, out_ch2, changed,
                  frame_done, change_count, output ready);
endinterface

>>> hdl/frame_change_detector.sv
// Frame change detector top level: frame store, compare stage and result register.
// Takes one pixel per clock unless the store is being cleared or the compare stage
// stalls. A pixel is read from the frame store in the cycle it is accepted, compared
// with the stored pixel in the next cycle and its result, if any, enters the output
// register when the compare stage advances. The store is a single-port-write,
// single-port-read memory of 2,097,152 entries; the write of one pixel is forwarded
// to a read of the same position in the same cycle. After reset the store is swept
// to zero, one entry per cycle; no pixel is accepted until it finishes,
// configuration writes are taken throughout. A result that waits on the output
// stalls the compare stage only when that stage also has a result to hand over.
module frame_change_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  fcd_pix_if.sink                       in_pix,
  fcd_res_if.source                     out_res,
  input  logic                          cfg_we,
  input  logic [fcd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [fcd_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  localparam logic [fcd_pkg::PIX_AW-1:0] LAST_ADDR = fcd_pkg::PIX_AW'(fcd_pkg::MAX_PIXELS - 1);

  // configuration
  logic [fcd_pkg::CH_W-1:0]   tol0_r, tol1_r, tol2_r;
  logic [fcd_pkg::MODE_W-1:0] mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol0_r <= '0;
      tol1_r <= '0;
      tol2_r <= '0;
      mode_r <= fcd_pkg::MODE_REPORT;
    end else if (cfg_we) begin
      unique case (fcd_pkg::cfg_idx_t'(cfg_idx))
        fcd_pkg::REG_TOL_CH0: tol0_r <= cfg_wdata;
        fcd_pkg::REG_TOL_CH1: tol1_r <= cfg_wdata;
        fcd_pkg::REG_TOL_CH2: tol2_r <= cfg_wdata;
        fcd_pkg::REG_MODE:    mode_r <= cfg_wdata[fcd_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  logic cmp_mode, wr_mode;
  assign cmp_mode = (mode_r == fcd_pkg::MODE_COUNT) || (mode_r == fcd_pkg::MODE_REPORT);
  assign wr_mode  = (mode_r != fcd_pkg::MODE_COUNT);

  // store clearing sweep
  logic                      clearing_r;
  logic [fcd_pkg::PIX_AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == LAST_ADDR) clearing_r <= 1'b0;
    end
  end

  // accept and position
  logic                       in_acc;
  logic                       s1_v_r, s1_adv, s1_res;
  logic [fcd_pkg::PIX_AW-1:0] pos_r, pos_nxt;

  assign in_pix.ready = !clearing_r && (!s1_v_r || s1_adv);
  assign in_acc       = in_pix.valid && in_pix.ready;

  always_comb begin
    if (in_pix.last_of_frame || pos_r == LAST_ADDR) pos_nxt = '0;
    else                                            pos_nxt = pos_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)      pos_r <= '0;
    else if (in_acc) pos_r <= pos_nxt;
  end

  // compare stage registers
  logic [fcd_pkg::PIX_AW-1:0] s1_addr_r;
  logic [fcd_pkg::PIX_W-1:0]  s1_pix_r;
  logic                       s1_last_r;
  logic [fcd_pkg::PIX_W-1:0]  rd_data_r, fwd_data_r;
  logic                       fwd_r;

  always_ff @(posedge clk) begin
    if (!rst_n)      s1_v_r <= 1'b0;
    else if (in_acc) s1_v_r <= 1'b1;
    else if (s1_adv) s1_v_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_addr_r  <= pos_r;
      s1_pix_r   <= {in_pix.pix_ch0, in_pix.pix_ch1, in_pix.pix_ch2};
      s1_last_r  <= in_pix.last_of_frame;
      fwd_r      <= s1_v_r && wr_mode && (s1_addr_r == pos_r);
      fwd_data_r <= s1_pix_r;
    end
  end

  // frame store
  logic [fcd_pkg::PIX_W-1:0] mem [fcd_pkg::MAX_PIXELS];

  always_ff @(posedge clk) begin
    if (clearing_r)                mem[clr_addr_r] <= '0;
    else if (s1_adv && wr_mode)    mem[s1_addr_r]  <= s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (in_acc) rd_data_r <= mem[pos_r];
  end

  // compare
  logic [fcd_pkg::PIX_W-1:0] old_pix;
  logic                      chg;
  logic [fcd_pkg::CNT_W-1:0] cnt_r, cnt_new;

  function automatic logic exceeds(input logic [fcd_pkg::CH_W-1:0] a,
                                   input logic [fcd_pkg::CH_W-1:0] b,
                                   input logic [fcd_pkg::CH_W-1:0] tol);
    logic [fcd_pkg::CH_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d > tol;
  endfunction

  assign old_pix = fwd_r ? fwd_data_r : rd_data_r;

  assign chg = exceeds(s1_pix_r[23:16], old_pix[23:16], tol0_r) ||
               exceeds(s1_pix_r[15:8],  old_pix[15:8],  tol1_r) ||
               exceeds(s1_pix_r[7:0],   old_pix[7:0],   tol2_r);

  assign cnt_new = (cmp_mode && chg && cnt_r != fcd_pkg::COUNT_MAX) ? cnt_r + 1'b1 : cnt_r;
  assign s1_res  = cmp_mode && (s1_last_r || (mode_r == fcd_pkg::MODE_REPORT && chg));
  assign s1_adv  = s1_v_r && (!s1_res || !out_res.valid || out_res.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else if (s1_adv) cnt_r <= s1_last_r ? '0 : cnt_new;
  end

  // result register
  logic out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n)                out_v_r <= 1'b0;
    else if (s1_adv && s1_res) out_v_r <= 1'b1;
    else if (out_res.ready)    out_v_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_res) begin
      out_res.pixel_index  <= fcd_pkg::IDX_W'(s1_addr_r);
      out_res.out_ch0      <= s1_pix_r[23:16];
      out_res.out_ch1      <= s1_pix_r[15:8];
      out_res.out_ch2      <= s1_pix_r[7:0];
      out_res.changed      <= chg;
      out_res.frame_done   <= s1_last_r;
      out_res.change_count <= cnt_new;
    end
  end

  assign out_res.valid = out_v_r;

  // checks
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !clearing_r) else $error("transaction accepted during store clear");

  a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_pix.last_of_frame |=> pos_r == '0) else $error("position not restarted");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_adv |=> s1_v_r && $stable(s1_addr_r) && $stable(s1_pix_r))
    else $error("compare stage lost its transaction");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_res.ready |-> !(s1_adv && s1_res))
    else $error("result register overwritten");

  a_count_frame: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_last_r |=> cnt_r == '0) else $error("count not cleared at frame end");

endmodule
